// File: rtl/zero_lag_moving_average_macros.svh
// ----------------------------------------------------------------------------
// Zero-lag moving average assertion macros
// Shared assertion forms used by the modules of the zero-lag moving average.
// ----------------------------------------------------------------------------
`ifndef ZERO_LAG_MOVING_AVERAGE_MACROS_SVH
`define ZERO_LAG_MOVING_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZLMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZLMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/zlma_pkg.sv
// ----------------------------------------------------------------------------
// Zero-lag moving average package
// Widths, constants, register codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package zlma_pkg;

  // Sample and fixed point format.
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;

  // History memory of past present samples.
  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int FILL_W     = HIST_AW + 1;

  // Seeding state.
  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int SUM_W   = 48;
  localparam int SPLIT_W = 24;

  // Lag width: whole part plus one for a fractional part.
  localparam int LAG_W = 9;

  // Shared multiplier and accumulator.
  localparam int MUL_A_W   = SAMPLE_W + 2;
  localparam int MUL_B_W   = FRAC_W + 2;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = SUM_W + MUL_B_W;
  localparam int HI_PROD_W = ACC_W - SPLIT_W;
  localparam int VALUE_W   = SAMPLE_W + 2;

  localparam logic [FRAC_W:0] Q_ONE = (FRAC_W + 1)'(1 << FRAC_W);
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_SEED_LEN   = 3'd0,
    REG_SEED_RECIP = 3'd1,
    REG_RATIO      = 3'd2,
    REG_LAG_WHOLE  = 3'd3,
    REG_LAG_FRAC   = 3'd4
  } reg_idx_t;

  localparam logic [8:0]  SEED_LEN_RST   = 9'd10;
  localparam logic [16:0] SEED_RECIP_RST = 17'd6554;
  localparam logic [15:0] RATIO_RST      = 16'd11916;
  localparam logic [7:0]  LAG_WHOLE_RST  = 8'd5;
  localparam logic [15:0] LAG_FRAC_RST   = 16'd32768;

  typedef struct packed {
    logic [8:0]  seed_len;
    logic [16:0] seed_recip;
    logic [15:0] ratio;
    logic [7:0]  lag_whole;
    logic [15:0] lag_frac;
  } cfg_t;

  // How the current item is handled.
  typedef enum logic [2:0] {
    KIND_GAPPED  = 3'd0,
    KIND_MISS    = 3'd1,
    KIND_SEEDING = 3'd2,
    KIND_SEED    = 3'd3,
    KIND_RUN     = 3'd4
  } kind_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MS_FAR     = 3'd0,
    MS_NEAR    = 3'd1,
    MS_VAL     = 3'd2,
    MS_PREV    = 3'd3,
    MS_SUM_HI  = 3'd4,
    MS_SUM_LO  = 3'd5
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_LOAD    = 2'd1,
    ACC_LOAD_HI = 2'd2,
    ACC_ADD     = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     accept;
    logic     eval;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     val_load;
    logic     res_load;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
  } dp_status_t;

endpackage

// File: rtl/zlma_cfg.sv
// ----------------------------------------------------------------------------
// Zero-lag moving average configuration registers
// Register bank behind the APB-style port, one register per word.
// ----------------------------------------------------------------------------
module zlma_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zlma_pkg::APB_AW-1:0] paddr,
  input  logic [zlma_pkg::APB_DW-1:0] pwdata,
  output logic [zlma_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output zlma_pkg::cfg_t             cfg
);
  import zlma_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed_len   <= SEED_LEN_RST;
      cfg.seed_recip <= SEED_RECIP_RST;
      cfg.ratio      <= RATIO_RST;
      cfg.lag_whole  <= LAG_WHOLE_RST;
      cfg.lag_frac   <= LAG_FRAC_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEED_LEN:   cfg.seed_len   <= pwdata[8:0];
        REG_SEED_RECIP: cfg.seed_recip <= pwdata[16:0];
        REG_RATIO:      cfg.ratio      <= pwdata[15:0];
        REG_LAG_WHOLE:  cfg.lag_whole  <= pwdata[7:0];
        REG_LAG_FRAC:   cfg.lag_frac   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (idx)
      REG_SEED_LEN:   prdata = APB_DW'(cfg.seed_len);
      REG_SEED_RECIP: prdata = APB_DW'(cfg.seed_recip);
      REG_RATIO:      prdata = APB_DW'(cfg.ratio);
      REG_LAG_WHOLE:  prdata = APB_DW'(cfg.lag_whole);
      REG_LAG_FRAC:   prdata = APB_DW'(cfg.lag_frac);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/zlma_datapath.sv
// ----------------------------------------------------------------------------
// Zero-lag moving average datapath
// Series state, sample history memory, shared multiplier and accumulator.
// ----------------------------------------------------------------------------
`include "zero_lag_moving_average_macros.svh"

module zlma_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  zlma_pkg::cfg_t                 cfg,
  input  zlma_pkg::dp_cmd_t              cmd,
  output zlma_pkg::dp_status_t           status,
  input  logic [zlma_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                           in_missing,
  input  logic                           in_start,
  output logic [zlma_pkg::SAMPLE_W-1:0]  out_average,
  output logic                           out_valid,
  output logic                           out_gap
);
  import zlma_pkg::*;

  // Item held while it is worked on.
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       miss_q;
  kind_t                      kind_q;

  // Series state.
  logic [SAMPLE_W-1:0]        hist [HIST_DEPTH];
  logic [HIST_AW-1:0]         head;
  logic [FILL_W-1:0]          fill;
  logic [COUNT_W-1:0]         count;
  logic signed [SUM_W-1:0]    seed_sum;
  logic signed [SAMPLE_W-1:0] prev;
  logic                       gap_seen;
  logic                       seeded;

  // Arithmetic registers.
  logic signed [SAMPLE_W-1:0] rd_far;
  logic signed [SAMPLE_W-1:0] rd_near;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [VALUE_W-1:0]  value;
  logic signed [SAMPLE_W-1:0] res;

  // Combinational terms.
  logic [COUNT_W-1:0]         need;
  logic [COUNT_W-1:0]         count_inc;
  logic signed [SUM_W-1:0]    sum_inc;
  kind_t                      kind;
  logic [LAG_W-1:0]           lag;
  logic [LAG_W-1:0]           far_diff;
  logic [LAG_W-1:0]           near_diff;
  logic signed [SAMPLE_W-1:0] far_term;
  logic signed [SAMPLE_W-1:0] near_term;
  logic [FRAC_W:0]            one_minus_f;
  logic [FRAC_W:0]            one_minus_r;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [SAMPLE_W-1:0] acc_sat;
  logic signed [SAMPLE_W-1:0] interp;
  logic                       push;
  logic                       had_present;

  // Seeding progress and item classification.
  assign need        = (cfg.seed_len == '0) ? COUNT_W'(1) : cfg.seed_len;
  assign count_inc   = (count < COUNT_MAX) ? count + 1'b1 : count;
  assign sum_inc     = seed_sum + SUM_W'(x_q);
  assign had_present = (count != '0) || seeded;

  always_comb begin
    if (gap_seen) begin
      kind = KIND_GAPPED;
    end else if (miss_q) begin
      kind = KIND_MISS;
    end else if (!seeded) begin
      kind = (count_inc >= need) ? KIND_SEED : KIND_SEEDING;
    end else begin
      kind = KIND_RUN;
    end
  end

  assign status.kind = kind;

  // History addresses of the two lag taps.
  assign lag       = LAG_W'(cfg.lag_whole) + LAG_W'(cfg.lag_frac != '0);
  assign far_diff  = LAG_W'(head) - lag;
  assign near_diff = LAG_W'(head) - lag + 1'b1;

  // Taps that lie before the series read as zero; a lag of one uses x itself.
  always_comb begin
    if (lag == '0) begin
      far_term  = x_q;
      near_term = '0;
    end else begin
      far_term = (LAG_W'(lag) > LAG_W'(fill)) ? '0 : rd_far;
      if (lag == LAG_W'(1)) begin
        near_term = x_q;
      end else begin
        near_term = ((lag - 1'b1) > LAG_W'(fill)) ? '0 : rd_near;
      end
    end
  end

  // Operand selection for the shared multiplier.
  assign one_minus_f = Q_ONE - (FRAC_W + 1)'(cfg.lag_frac);
  assign one_minus_r = Q_ONE - (FRAC_W + 1)'(cfg.ratio);

  always_comb begin
    case (cmd.mul_sel)
      MS_FAR: begin
        mul_a = MUL_A_W'(far_term);
        mul_b = $signed({1'b0, one_minus_f});
      end
      MS_NEAR: begin
        mul_a = MUL_A_W'(near_term);
        mul_b = $signed({2'b00, cfg.lag_frac});
      end
      MS_VAL: begin
        mul_a = MUL_A_W'(value);
        mul_b = $signed({2'b00, cfg.ratio});
      end
      MS_PREV: begin
        mul_a = MUL_A_W'(prev);
        mul_b = $signed({1'b0, one_minus_r});
      end
      MS_SUM_HI: begin
        mul_a = MUL_A_W'($signed(sum_inc[SUM_W-1:SPLIT_W]));
        mul_b = $signed({1'b0, cfg.seed_recip});
      end
      MS_SUM_LO: begin
        mul_a = $signed({{(MUL_A_W - SPLIT_W){1'b0}}, sum_inc[SPLIT_W-1:0]});
        mul_b = $signed({1'b0, cfg.seed_recip});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round half up, then clamp to the sample range.
  assign acc_rnd = (acc + ROUND_ADD) >>> FRAC_W;
  assign interp  = acc_rnd[SAMPLE_W-1:0];

  always_comb begin
    if (acc_rnd > SAT_MAX) begin
      acc_sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (acc_rnd < SAT_MIN) begin
      acc_sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      acc_sat = acc_rnd[SAMPLE_W-1:0];
    end
  end

  // Item capture and the arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_q    <= in_sample;
      miss_q <= in_missing;
    end
    if (cmd.eval) begin
      kind_q <= kind;
    end
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      ACC_LOAD:    acc <= ACC_W'(prod);
      ACC_LOAD_HI: acc <= $signed({prod[HI_PROD_W-1:0], {SPLIT_W{1'b0}}});
      ACC_ADD:     acc <= acc + ACC_W'(prod);
      default:     acc <= acc;
    endcase
    if (cmd.val_load) begin
      value <= (VALUE_W'(x_q) <<< 1) - VALUE_W'(interp);
    end
    if (cmd.res_load) begin
      res <= acc_sat;
    end
  end

  // History memory: both taps read in the evaluation cycle, one write on commit.
  assign push = (kind_q == KIND_SEEDING) || (kind_q == KIND_SEED) || (kind_q == KIND_RUN);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rd_far  <= hist[far_diff[HIST_AW-1:0]];
      rd_near <= hist[near_diff[HIST_AW-1:0]];
    end
    if (cmd.commit && push) begin
      hist[head] <= x_q;
    end
  end

  // Series state: cleared by a series start, updated when the result is handed over.
  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && in_start)) begin
      head     <= '0;
      fill     <= '0;
      count    <= '0;
      seed_sum <= '0;
      prev     <= '0;
      gap_seen <= 1'b0;
      seeded   <= 1'b0;
    end else if (cmd.commit) begin
      case (kind_q) inside
        KIND_MISS: begin
          gap_seen <= had_present;
        end
        KIND_SEEDING, KIND_SEED, KIND_RUN: begin
          head <= head + 1'b1;
          if (fill < FILL_W'(HIST_DEPTH)) begin
            fill <= fill + 1'b1;
          end
          if (kind_q != KIND_RUN) begin
            count    <= count_inc;
            seed_sum <= sum_inc;
          end
          if (kind_q != KIND_SEEDING) begin
            prev   <= res;
            seeded <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register, loaded when the result is handed over.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (kind_q) inside
        KIND_SEED, KIND_RUN: begin
          out_average <= res;
          out_valid   <= 1'b1;
          out_gap     <= 1'b0;
        end
        KIND_GAPPED: begin
          out_average <= '0;
          out_valid   <= 1'b0;
          out_gap     <= 1'b1;
        end
        KIND_MISS: begin
          out_average <= '0;
          out_valid   <= 1'b0;
          out_gap     <= had_present;
        end
        default: begin
          out_average <= '0;
          out_valid   <= 1'b0;
          out_gap     <= 1'b0;
        end
      endcase
    end
  end

  // The seed becomes the previous average and ends seeding.
  `ZLMA_ASSERT_NEXT(a_seed_sets_state, clk, rst, cmd.commit && kind_q == KIND_SEED, seeded && prev == $past(res), "seed result not taken into state")
  // After a gap the series state stays frozen.
  `ZLMA_ASSERT_NEXT(a_gap_freezes, clk, rst, cmd.commit && kind_q == KIND_GAPPED, $stable(head) && $stable(fill) && gap_seen, "state changed after a gap")
  // A running sample advances the history head by one.
  `ZLMA_ASSERT_NEXT(a_run_pushes, clk, rst, cmd.commit && kind_q == KIND_RUN, head == $past(head) + 1'b1, "history head did not advance")

endmodule

// File: rtl/zlma_ctrl.sv
// ----------------------------------------------------------------------------
// Zero-lag moving average controller
// Sequences one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`include "zero_lag_moving_average_macros.svh"

module zlma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  zlma_pkg::dp_status_t status,
  output zlma_pkg::dp_cmd_t    cmd
);
  import zlma_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_EVAL = 14'b00000000000010,
    S_SH   = 14'b00000000000100,
    S_SL   = 14'b00000000001000,
    S_SA   = 14'b00000000010000,
    S_MF   = 14'b00000000100000,
    S_MN   = 14'b00000001000000,
    S_IA   = 14'b00000010000000,
    S_VAL  = 14'b00000100000000,
    S_MV   = 14'b00001000000000,
    S_MP   = 14'b00010000000000,
    S_AA   = 14'b00100000000000,
    S_FIN  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = MS_FAR;
    cmd.acc_op   = ACC_HOLD;
    unique case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        unique case (status.kind)
          KIND_SEED: state_next = S_SH;
          KIND_RUN:  state_next = S_MF;
          default:   state_next = S_DONE;
        endcase
      end
      // Seed: high and low halves of the sum times the reciprocal.
      S_SH: begin
        cmd.mul_sel = MS_SUM_HI;
        state_next  = S_SL;
      end
      S_SL: begin
        cmd.mul_sel = MS_SUM_LO;
        cmd.acc_op  = ACC_LOAD_HI;
        state_next  = S_SA;
      end
      S_SA: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_FIN;
      end
      // Running average: interpolated lag term, then the weighted blend.
      S_MF: begin
        cmd.mul_sel = MS_FAR;
        state_next  = S_MN;
      end
      S_MN: begin
        cmd.mul_sel = MS_NEAR;
        cmd.acc_op  = ACC_LOAD;
        state_next  = S_IA;
      end
      S_IA: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_VAL;
      end
      S_VAL: begin
        cmd.val_load = 1'b1;
        state_next   = S_MV;
      end
      S_MV: begin
        cmd.mul_sel = MS_VAL;
        state_next  = S_MP;
      end
      S_MP: begin
        cmd.mul_sel = MS_PREV;
        cmd.acc_op  = ACC_LOAD;
        state_next  = S_AA;
      end
      S_AA: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        cmd.commit = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set when a result is handed over, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // An accepted item is evaluated in the following cycle.
  `ZLMA_ASSERT_NEXT(a_accept_eval, clk, rst, s_tvalid && s_tready, state == S_EVAL, "accepted item not evaluated")
  // A handed-over result is offered and the block returns to idle.
  `ZLMA_ASSERT_NEXT(a_commit_offer, clk, rst, cmd.commit, m_tvalid && state == S_IDLE, "result not offered after commit")
  // Items that need no arithmetic go straight to hand-over.
  `ZLMA_ASSERT_NEXT(a_short_path, clk, rst, state == S_EVAL && (status.kind == KIND_GAPPED || status.kind == KIND_MISS || status.kind == KIND_SEEDING), state == S_DONE, "short item took the long path")

endmodule

// File: rtl/zero_lag_moving_average.sv
// ----------------------------------------------------------------------------
// Zero-lag moving average
// Zero-lag exponential moving average over signed Q16.16 price items.
// ----------------------------------------------------------------------------
// One result item leaves for every input item, in order. An item that needs
// no arithmetic (missing, still seeding, or after a gap) goes from S_EVAL to
// S_DONE; the item completing the seed runs S_SH to S_SA, then S_FIN; every
// later item runs S_MF to S_AA, then S_FIN, as a single shared multiplier forms
// the four products of the interpolated lag term and the weighted blend one
// after another, each followed by an accumulate. S_IDLE lies between items.
// A new item is accepted while the previous result still waits in the output
// register; it stalls only at hand-over. The history memory needs no clearing
// pass: a fill count marks which entries belong to the current series.
// ----------------------------------------------------------------------------
module zero_lag_moving_average (
  input  logic                        clk,
  input  logic                        rst,
  // Input items.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,  // [31:0] sample
  input  logic [1:0]                  s_tuser,  // [0] sample_missing, [1] series_start
  // Result items.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // [31:0] average
  output logic [1:0]                  m_tuser,  // [0] average_valid, [1] gap_error
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zlma_pkg::APB_AW-1:0] paddr,
  input  logic [zlma_pkg::APB_DW-1:0] pwdata,
  output logic [zlma_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import zlma_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Register bank.
  zlma_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  zlma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and series state.
  zlma_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .in_sample   (s_tdata),
    .in_missing  (s_tuser[0]),
    .in_start    (s_tuser[1]),
    .out_average (m_tdata),
    .out_valid   (m_tuser[0]),
    .out_gap     (m_tuser[1])
  );

endmodule

// File: tb/tb_zero_lag_moving_average.sv
// ----------------------------------------------------------------------------
// Zero-lag moving average testbench
// Drives price items into the block through its stream input and writes the
// configuration registers over the APB port while the block is idle. A
// predictor in this file computes every expected result item, and each result
// item is compared field by field with the oldest prediction. Both stream
// sides idle in random bursts, and once the receiver stalls for a long
// stretch so that the block fills up and holds off its input.
// ----------------------------------------------------------------------------
module tb_zero_lag_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import zlma_pkg::*;

  // One input item and one result item as the block sees them.
  typedef struct packed {
    logic [31:0] sample;
    logic        missing;
    logic        start;
  } price_item_t;

  typedef struct packed {
    logic [31:0] average;
    logic        valid;
    logic        gap;
  } average_result_t;

  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] sample
  logic [1:0]  s_tuser = '0;   // [0] sample_missing, [1] series_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] average
  logic [1:0]  m_tuser;        // [0] average_valid, [1] gap_error

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  zero_lag_moving_average uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Stimulus bookkeeping shared by the processes.
  price_item_t     pending_items[$];
  average_result_t expected_averages[$];
  int unsigned     queued = 0;
  int unsigned     offered = 0;
  int unsigned     taken = 0;
  int unsigned     mismatches = 0;
  int              idle_pct = 0;
  bit              pressure = 1'b0;
  int unsigned     hold_req = 0;
  longint          walk_level = 0;

  // Predictor state and its copy of the configuration.
  cfg_t        cfg;
  longint      price_hist[HIST_DEPTH];
  int          hist_head;
  int          hist_fill;
  int          present_cnt;
  longint      seed_sum;
  longint      prev_avg;
  bit          gap_seen;
  bit          seeded;

  function automatic void clear_series();
    hist_head   = 0;
    hist_fill   = 0;
    present_cnt = 0;
    seed_sum    = 0;
    prev_avg    = 0;
    gap_seen    = 1'b0;
    seeded      = 1'b0;
  endfunction

  function automatic void reset_predictor();
    cfg.seed_len   = SEED_LEN_RST;
    cfg.seed_recip = SEED_RECIP_RST;
    cfg.ratio      = RATIO_RST;
    cfg.lag_whole  = LAG_WHOLE_RST;
    cfg.lag_frac   = LAG_FRAC_RST;
    clear_series();
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [31:0] val);
    case (idx)
      REG_SEED_LEN:   cfg.seed_len   = val[8:0];
      REG_SEED_RECIP: cfg.seed_recip = val[16:0];
      REG_RATIO:      cfg.ratio      = val[15:0];
      REG_LAG_WHOLE:  cfg.lag_whole  = val[7:0];
      REG_LAG_FRAC:   cfg.lag_frac   = val[15:0];
      default: ;
    endcase
  endfunction

  // Q0.16 products round half up; the shift of a signed value is a floor.
  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> FRAC_W;
  endfunction

  function automatic longint saturate(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Present sample k places back; zero when it is not held.
  function automatic longint past_sample(longint k);
    if (k == 0 || k > hist_fill || k > HIST_DEPTH) return 0;
    return price_hist[(hist_head + HIST_DEPTH - int'(k)) % HIST_DEPTH];
  endfunction

  function automatic void push_history(longint x);
    price_hist[hist_head] = x;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    if (hist_fill < HIST_DEPTH) hist_fill++;
  endfunction

  function automatic average_result_t predict_average(price_item_t item);
    longint          x, far_t, near_t, interp, value, acc, avg, f, lag;
    int              need;
    average_result_t res;
    x = $signed(item.sample);
    avg = 0;
    res.valid = 1'b0;
    if (item.start) clear_series();
    if (!gap_seen) begin
      if (item.missing) begin
        // A missing sample only counts as a gap once the series has begun.
        if (present_cnt > 0 || seeded) gap_seen = 1'b1;
      end else if (!seeded) begin
        need = (cfg.seed_len == 0) ? 1 : int'(cfg.seed_len);
        seed_sum += x;
        if (present_cnt < 511) present_cnt++;
        if (present_cnt >= need) begin
          avg = saturate(round_q16(seed_sum * longint'(cfg.seed_recip)));
          prev_avg = avg;
          seeded = 1'b1;
          res.valid = 1'b1;
        end
        push_history(x);
      end else begin
        // Interpolate the lagged sample, then blend with the last average.
        f = longint'(cfg.lag_frac);
        lag = longint'(cfg.lag_whole) + ((f != 0) ? 1 : 0);
        far_t = (lag == 0) ? x : past_sample(lag);
        near_t = (lag == 0) ? 0 : ((lag == 1) ? x : past_sample(lag - 1));
        interp = round_q16((65536 - f) * far_t + f * near_t);
        value = 2 * x - interp;
        acc = longint'(cfg.ratio) * value + (65536 - longint'(cfg.ratio)) * prev_avg;
        avg = saturate(round_q16(acc));
        prev_avg = avg;
        res.valid = 1'b1;
        push_history(x);
      end
    end
    if (gap_seen) begin
      avg = 0;
      res.valid = 1'b0;
    end
    res.average = avg[31:0];
    res.gap = gap_seen;
    return res;
  endfunction

  function automatic void note_mismatch(string field, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0d (0x%h), got %0d (0x%h)",
               $realtime, field, exp_v, exp_v[31:0], act_v, act_v[31:0]);
  endfunction

  // Check each result item, then predict for each accepted input item.
  always @(posedge clk) begin
    average_result_t exp_r;
    price_item_t     in_item;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_averages.size() == 0) begin
          note_mismatch("unexpected result average", 0, $signed(m_tdata));
        end else begin
          exp_r = expected_averages.pop_front();
          if (m_tdata !== exp_r.average)
            note_mismatch("average", $signed(exp_r.average), $signed(m_tdata));
          if (m_tuser[0] !== exp_r.valid)
            note_mismatch("average_valid", exp_r.valid, m_tuser[0]);
          if (m_tuser[1] !== exp_r.gap)
            note_mismatch("gap_error", exp_r.gap, m_tuser[1]);
        end
      end
      if (s_tvalid && s_tready) begin
        in_item.sample  = s_tdata;
        in_item.missing = s_tuser[0];
        in_item.start   = s_tuser[1];
        expected_averages.push_back(predict_average(in_item));
        taken++;
      end
    end
  end

  // Sender: offers pending items, idling in random bursts.
  int send_gap = 0;
  always @(negedge clk) begin
    price_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken == offered) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!pressure && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(1, 15) - 1;
        s_tvalid <= 1'b0;
      end else begin
        item = pending_items.pop_front();
        s_tdata  <= item.sample;
        s_tuser  <= {item.start, item.missing};
        s_tvalid <= 1'b1;
        offered++;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  int          recv_gap = 0;
  int          hold_left = 0;
  int unsigned hold_done = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    // The register takes the value at this edge.
    @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(int len, int recip, int rat, int whole, int frac);
    write_reg(REG_SEED_LEN, len);
    write_reg(REG_SEED_RECIP, recip);
    write_reg(REG_RATIO, rat);
    write_reg(REG_LAG_WHOLE, whole);
    write_reg(REG_LAG_FRAC, frac);
  endtask

  function automatic void push_item(logic [31:0] sample, logic missing, logic start);
    price_item_t item;
    item.sample  = sample;
    item.missing = missing;
    item.start   = start;
    pending_items.push_back(item);
    queued++;
  endfunction

  // Wait until every result has come back and the block has settled.
  task automatic wait_idle();
    while (taken != queued || expected_averages.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic start_phase(int pct);
    @(posedge clk);
    idle_pct = pct;
  endtask

  // Sample content: raw random bits, a slow price walk, or the extremes.
  function automatic logic [31:0] pick_sample(int mode);
    case (mode)
      0: return $urandom();
      1: begin
        walk_level += longint'($urandom_range(0, 131072)) - 65536;
        walk_level = saturate(walk_level);
        return walk_level[31:0];
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // One series: optional leading missing items, present samples, maybe a gap.
  task automatic queue_series(int n);
    int   lead, gap_at, mode;
    logic first;
    mode = $urandom_range(0, 2);
    if (mode == 1) walk_level = longint'($signed($urandom())) / 4;
    first = ($urandom_range(0, 7) != 0);
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    gap_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < lead; i++) begin
      push_item($urandom(), 1'b1, first);
      first = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == gap_at) push_item($urandom(), 1'b1, first);
      else push_item(pick_sample(mode), 1'b0, first);
      first = 1'b0;
    end
  endtask

  task automatic random_config();
    int len, recip, rat, whole, frac;
    case ($urandom_range(0, 5))
      0: len = 1;
      4: len = $urandom_range(13, 40);
      5: len = $urandom_range(0, 511);
      default: len = $urandom_range(2, 12);
    endcase
    if ($urandom_range(0, 4) == 0) recip = $urandom_range(1, 65536);
    else recip = (len == 0) ? 65536 : 65536 / len;
    case ($urandom_range(0, 4))
      0: rat = 1;
      1: rat = 65535;
      default: rat = $urandom_range(1, 65535);
    endcase
    case ($urandom_range(0, 4))
      0: whole = 0;
      1: whole = 255;
      2: whole = $urandom_range(0, 255);
      default: whole = $urandom_range(0, 8);
    endcase
    case ($urandom_range(0, 3))
      0: frac = 0;
      1: frac = 65535;
      default: frac = $urandom_range(0, 65535);
    endcase
    write_all(len, recip, rat, whole, frac);
  endtask

  initial begin
    int unsigned phase_end;
    reset_predictor();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Leading missing, seeding, extreme samples, a gap and a restart.
    write_all(2, 32768, 32768, 1, 32768);
    start_phase(10);
    push_item(32'h7FFF_FFFF, 1'b1, 1'b1);
    push_item(32'h0000_0000, 1'b1, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'h0000_0000, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(32'h0001_0000, 1'b0, 1'b0);
    push_item(32'h5555_AAAA, 1'b1, 1'b0);
    push_item(32'h1234_5678, 1'b0, 1'b0);
    push_item(32'hAAAA_5555, 1'b1, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b1);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    wait_idle();

    // Seed length zero, zero lag and zero ratio; then the top ratio.
    write_all(0, 65536, 0, 0, 0);
    start_phase(10);
    push_item(32'h4000_0000, 1'b0, 1'b1);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_RATIO, 65535);
    start_phase(0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'hC000_0000, 1'b0, 1'b0);
    wait_idle();

    // Seed length lowered below the samples already summed.
    write_all(10, 6554, 11916, 5, 32768);
    start_phase(10);
    push_item(32'h0010_0000, 1'b0, 1'b1);
    for (int i = 0; i < 3; i++) push_item($urandom(), 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_SEED_LEN, 3);
    start_phase(10);
    push_item(32'h0020_0000, 1'b0, 1'b0);
    push_item(32'h0030_0000, 1'b0, 1'b0);
    wait_idle();

    // A seed as long as the history and a lag that reaches the whole history.
    write_all(256, 256, 1, 255, 65535);
    start_phase(10);
    walk_level = 64'sd6553600;
    push_item(pick_sample(1), 1'b0, 1'b1);
    for (int i = 1; i < 265; i++) push_item(pick_sample(1), 1'b0, 1'b0);
    wait_idle();

    // Random settings, with one long receiver hold-off along the way.
    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      start_phase((phase % 3 == 2) ? 0 : 4 * $urandom_range(1, 6));
      phase_end = queued + 22;
      while (queued < phase_end) queue_series($urandom_range(3, 20));
      if (phase == 3) begin
        pressure = 1'b1;
        hold_req++;
      end
      wait_idle();
      pressure = 1'b0;
    end

    // Closing stretch without any idling.
    write_all(4, 16384, 21845, 2, 0);
    start_phase(0);
    phase_end = queued + 30;
    while (queued < phase_end) queue_series($urandom_range(5, 15));
    wait_idle();
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
